FILE: design/mlfq_process_table_assert.svh
// Assertion macros for the process table. Each macro expects clk and rst_n in scope.
`ifndef MLFQ_PROCESS_TABLE_ASSERT_SVH
`define MLFQ_PROCESS_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define MLFQ_ASSERT_IMP(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("mlfq process table: assertion failed");
`define MLFQ_ASSERT_NXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("mlfq process table: assertion failed");
`else
`define MLFQ_ASSERT_IMP(label, cond, prop)
`define MLFQ_ASSERT_NXT(label, cond, prop)
`endif
`endif

FILE: design/mlfq_pkg.sv
package mlfq_pkg;

    localparam int NUM_SLOTS_DEF  = 16;
    localparam int NUM_LEVELS_DEF = 5;

    localparam int LEVEL_W   = 3;
    localparam int PID_W     = 16;
    localparam int RT_W      = 32;
    localparam int TIME_W    = 64;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;
    localparam int LIMIT_W   = RT_W + LEVEL_W + 1;

    localparam logic [RT_W-1:0]  BASE_QUANTUM_RST = 32'd100000;
    localparam logic [RT_W-1:0]  RESET_PERIOD_RST = 32'd10000000;
    localparam logic [PID_W-1:0] SHELL_PID_RST    = 16'd1;

    typedef enum logic [1:0] {
        REQ_ALLOC  = 2'd0,
        REQ_CHARGE = 2'd1,
        REQ_FREE   = 2'd2,
        REQ_NOP    = 2'd3
    } req_kind_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_NOT_FOUND = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_QUANTUM = 2'd0,
        CFG_RESET_PERIOD = 2'd1,
        CFG_SHELL_PID    = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ALLOC,
        ST_LOAD,
        ST_APPLY,
        ST_BOOST,
        ST_FLUSH,
        ST_FINISH
    } seq_state_t;

    typedef enum logic [2:0] {
        TBL_NOP,
        TBL_ALLOC,
        TBL_FREE,
        TBL_WRITE,
        TBL_FLUSH
    } tbl_op_t;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [PID_W-1:0]  pid;
        logic [RT_W-1:0]   runtime;
        logic [TIME_W-1:0] now_time;
        logic              tty_pending;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [PID_W-1:0]   pid_out;
        logic [LEVEL_W-1:0] level_out;
        logic               demoted;
        logic               global_reset;
    } rsp_t;

    typedef struct packed {
        tbl_op_t            op;
        logic [PID_W-1:0]   pid;
        logic [LEVEL_W-1:0] level;
        logic [RT_W-1:0]    runtime;
    } tbl_wr_t;

    typedef struct packed {
        logic               demote;
        logic [LEVEL_W-1:0] level;
        logic [RT_W-1:0]    runtime;
        logic               due;
    } alu_res_t;

endpackage

FILE: design/mlfq_process_table.sv
// Process table for a multilevel feedback queue scheduler. Each request but a no-op
// walks the table one slot per cycle through a single read port and a pair of pid
// comparators. An allocate then writes the first free slot that the scan found, a free
// clears the matching slot during the scan, and a charge goes on from the scan through
// the multiply and add, the entry update, the shell boost and the periodic reset; a
// no-op request skips the scan. One request is in progress at a time; the result sits
// in an output register, so the next request may be accepted while it waits.
`include "mlfq_process_table_assert.svh"

module mlfq_process_table
    import mlfq_pkg::*;
#(
    parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
    parameter int NUM_LEVELS = NUM_LEVELS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  req_t                 req,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output rsp_t                 rsp,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    localparam int IDX_W = $clog2(NUM_SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

    seq_state_t           state_reg, state_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     s_reg, s_next;
    logic                 found_k_reg, found_k_next;
    logic [IDX_W-1:0]     k_reg, k_next;
    logic [LEVEL_W-1:0]   lvl_reg, lvl_next;
    logic                 demoted_reg, demoted_next;
    logic                 gres_reg, gres_next;
    logic [PID_W-1:0]     pid_cnt_reg, pid_cnt_next;
    logic [TIME_W-1:0]    last_reset_reg, last_reset_next;
    req_t                 req_reg, req_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    rsp_t                 rsp_reg, rsp_next;
    logic                 rsp_load;
    logic [RT_W-1:0]      base_quantum_reg;
    logic [RT_W-1:0]      reset_period_reg;
    logic [PID_W-1:0]     shell_pid_reg;

    logic [IDX_W-1:0]     rd_idx;
    logic                 rd_used;
    logic [PID_W-1:0]     rd_pid;
    logic [LEVEL_W-1:0]   rd_level;
    logic [RT_W-1:0]      rd_runtime;
    logic [IDX_W-1:0]     wr_idx;
    tbl_wr_t              wr;
    logic [NUM_SLOTS-1:0] used_vec;
    logic                 alu_load;
    alu_res_t             alu_res;
    logic                 hit_p;
    logic                 hit_k;

    mlfq_table_store #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_idx     (rd_idx),
        .rd_used    (rd_used),
        .rd_pid     (rd_pid),
        .rd_level   (rd_level),
        .rd_runtime (rd_runtime),
        .wr_idx     (wr_idx),
        .wr         (wr),
        .used_vec   (used_vec)
    );

    mlfq_charge_alu #(
        .NUM_LEVELS (NUM_LEVELS)
    ) u_alu (
        .clk          (clk),
        .load         (alu_load),
        .cur_runtime  (rd_runtime),
        .cur_level    (rd_level),
        .add_runtime  (req_reg.runtime),
        .base_quantum (base_quantum_reg),
        .now_time     (req_reg.now_time),
        .last_reset   (last_reset_reg),
        .reset_period (reset_period_reg),
        .res          (alu_res)
    );

    assign hit_p = rd_used && (rd_pid == req_reg.pid);
    assign hit_k = rd_used && (rd_pid == shell_pid_reg);

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        found_next      = found_reg;
        s_next          = s_reg;
        found_k_next    = found_k_reg;
        k_next          = k_reg;
        lvl_next        = lvl_reg;
        demoted_next    = demoted_reg;
        gres_next       = gres_reg;
        pid_cnt_next    = pid_cnt_reg;
        last_reset_next = last_reset_reg;
        req_next        = req_reg;
        rd_idx          = idx_reg;
        wr_idx          = idx_reg;
        wr.op           = TBL_NOP;
        wr.pid          = '0;
        wr.level        = '0;
        wr.runtime      = '0;
        alu_load        = 1'b0;
        rsp_load        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next     = req;
                    idx_next     = '0;
                    found_next   = 1'b0;
                    found_k_next = 1'b0;
                    lvl_next     = '0;
                    demoted_next = 1'b0;
                    gres_next    = 1'b0;
                    state_next   = (req.req_type == REQ_NOP) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                case (req_reg.req_type)
                    REQ_ALLOC:
                    begin
                        if (!rd_used && !found_reg)
                        begin
                            found_next = 1'b1;
                            s_next     = idx_reg;
                        end
                    end
                    REQ_CHARGE:
                    begin
                        if (hit_p && !found_reg)
                        begin
                            found_next = 1'b1;
                            s_next     = idx_reg;
                        end
                        if (hit_k && !found_k_reg)
                        begin
                            found_k_next = 1'b1;
                            k_next       = idx_reg;
                        end
                    end
                    REQ_FREE:
                    begin
                        if (hit_p)
                        begin
                            found_next = 1'b1;
                            wr.op      = TBL_FREE;
                        end
                    end
                    default: ;
                endcase
                idx_next = idx_reg + IDX_W'(1);
                if (idx_reg == LAST_IDX)
                begin
                    case (req_reg.req_type)
                        REQ_ALLOC:  state_next = ST_ALLOC;
                        REQ_CHARGE: state_next = ST_LOAD;
                        default:    state_next = ST_FINISH;
                    endcase
                end
            end
            ST_ALLOC:
            begin
                wr_idx = s_reg;
                if (found_reg)
                begin
                    pid_cnt_next = pid_cnt_reg + PID_W'(1);
                    wr.op        = TBL_ALLOC;
                    wr.pid       = pid_cnt_next;
                end
                state_next = ST_FINISH;
            end
            ST_LOAD:
            begin
                rd_idx     = s_reg;
                alu_load   = 1'b1;
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                wr_idx = s_reg;
                if (found_reg)
                begin
                    wr.op        = TBL_WRITE;
                    wr.level     = alu_res.level;
                    wr.runtime   = alu_res.runtime;
                    lvl_next     = alu_res.level;
                    demoted_next = alu_res.demote;
                end
                state_next = ST_BOOST;
            end
            ST_BOOST:
            begin
                wr_idx = k_reg;
                if (req_reg.tty_pending && found_k_reg)
                begin
                    wr.op = TBL_WRITE;
                    if (found_reg && (k_reg == s_reg))
                    begin
                        lvl_next = '0;
                    end
                end
                state_next = ST_FLUSH;
            end
            ST_FLUSH:
            begin
                if (alu_res.due)
                begin
                    wr.op           = TBL_FLUSH;
                    last_reset_next = req_reg.now_time;
                    gres_next       = 1'b1;
                    lvl_next        = '0;
                end
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_next.pid_out      = req_reg.pid;
        rsp_next.level_out    = '0;
        rsp_next.demoted      = demoted_reg;
        rsp_next.global_reset = gres_reg;
        rsp_next.status       = STAT_OK;
        case (req_reg.req_type)
            REQ_ALLOC:
            begin
                rsp_next.status  = found_reg ? STAT_OK : STAT_FULL;
                rsp_next.pid_out = found_reg ? pid_cnt_reg : '0;
            end
            REQ_CHARGE:
            begin
                rsp_next.status    = found_reg ? STAT_OK : STAT_NOT_FOUND;
                rsp_next.level_out = found_reg ? lvl_reg : '0;
            end
            REQ_FREE:
            begin
                rsp_next.status = found_reg ? STAT_OK : STAT_NOT_FOUND;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            idx_reg          <= '0;
            found_reg        <= 1'b0;
            found_k_reg      <= 1'b0;
            demoted_reg      <= 1'b0;
            gres_reg         <= 1'b0;
            pid_cnt_reg      <= '0;
            last_reset_reg   <= '0;
            rsp_valid_reg    <= 1'b0;
            base_quantum_reg <= BASE_QUANTUM_RST;
            reset_period_reg <= RESET_PERIOD_RST;
            shell_pid_reg    <= SHELL_PID_RST;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            found_reg      <= found_next;
            found_k_reg    <= found_k_next;
            demoted_reg    <= demoted_next;
            gres_reg       <= gres_next;
            pid_cnt_reg    <= pid_cnt_next;
            last_reset_reg <= last_reset_next;
            rsp_valid_reg  <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_BASE_QUANTUM: base_quantum_reg <= cfg_data[RT_W-1:0];
                    CFG_RESET_PERIOD: reset_period_reg <= cfg_data[RT_W-1:0];
                    CFG_SHELL_PID:    shell_pid_reg    <= cfg_data[PID_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        s_reg   <= s_next;
        k_reg   <= k_next;
        lvl_reg <= lvl_next;
        if (rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign cfg_ready = 1'b1;

    `MLFQ_ASSERT_IMP(a_rsp_from_finish, $rose(rsp_valid_reg), $past(state_reg) == ST_FINISH)
    `MLFQ_ASSERT_IMP(a_full_only_when_full, rsp_load && (rsp_next.status == STAT_FULL), &used_vec)
    `MLFQ_ASSERT_IMP(a_demote_on_success, rsp_valid_reg && rsp_reg.demoted, rsp_reg.status == STAT_OK)
    `MLFQ_ASSERT_NXT(a_pid_advance, (state_reg == ST_ALLOC) && found_reg, pid_cnt_reg == PID_W'($past(pid_cnt_reg) + PID_W'(1)))

endmodule

FILE: design/mlfq_table_store.sv
module mlfq_table_store
    import mlfq_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF,
    localparam int IDX_W = $clog2(NUM_SLOTS)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [IDX_W-1:0]     rd_idx,
    output logic                 rd_used,
    output logic [PID_W-1:0]     rd_pid,
    output logic [LEVEL_W-1:0]   rd_level,
    output logic [RT_W-1:0]      rd_runtime,
    input  logic [IDX_W-1:0]     wr_idx,
    input  tbl_wr_t              wr,
    output logic [NUM_SLOTS-1:0] used_vec
);

    logic [NUM_SLOTS-1:0] used_reg;
    logic [NUM_SLOTS-1:0] used_next;
    logic [PID_W-1:0]     pid_reg     [NUM_SLOTS];
    logic [LEVEL_W-1:0]   level_reg   [NUM_SLOTS];
    logic [RT_W-1:0]      runtime_reg [NUM_SLOTS];

    always_comb
    begin
        used_next = used_reg;
        case (wr.op)
            TBL_ALLOC: used_next[wr_idx] = 1'b1;
            TBL_FREE:  used_next[wr_idx] = 1'b0;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else
        begin
            used_reg <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (wr.op)
            TBL_ALLOC:
            begin
                pid_reg[wr_idx]     <= wr.pid;
                level_reg[wr_idx]   <= wr.level;
                runtime_reg[wr_idx] <= wr.runtime;
            end
            TBL_WRITE:
            begin
                level_reg[wr_idx]   <= wr.level;
                runtime_reg[wr_idx] <= wr.runtime;
            end
            TBL_FLUSH:
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    level_reg[i]   <= '0;
                    runtime_reg[i] <= '0;
                end
            end
            default: ;
        endcase
    end

    assign rd_used    = used_reg[rd_idx];
    assign rd_pid     = pid_reg[rd_idx];
    assign rd_level   = level_reg[rd_idx];
    assign rd_runtime = runtime_reg[rd_idx];
    assign used_vec   = used_reg;

endmodule

FILE: design/mlfq_charge_alu.sv
module mlfq_charge_alu
    import mlfq_pkg::*;
#(
    parameter int NUM_LEVELS = NUM_LEVELS_DEF
)
(
    input  logic               clk,
    input  logic               load,
    input  logic [RT_W-1:0]    cur_runtime,
    input  logic [LEVEL_W-1:0] cur_level,
    input  logic [RT_W-1:0]    add_runtime,
    input  logic [RT_W-1:0]    base_quantum,
    input  logic [TIME_W-1:0]  now_time,
    input  logic [TIME_W-1:0]  last_reset,
    input  logic [RT_W-1:0]    reset_period,
    output alu_res_t           res
);

    localparam logic [LEVEL_W-1:0] LAST_LEVEL = LEVEL_W'(NUM_LEVELS - 1);

    logic [RT_W:0]        sum_wide;
    logic [RT_W-1:0]      sum_next;
    logic [LIMIT_W-1:0]   limit_next;
    logic [TIME_W-1:0]    elapsed;
    logic                 due_next;
    logic [RT_W-1:0]      sum_reg;
    logic [LIMIT_W-1:0]   limit_reg;
    logic [LEVEL_W-1:0]   level_reg;
    logic                 due_reg;
    logic                 demote;

    always_comb
    begin
        sum_wide   = {1'b0, cur_runtime} + {1'b0, add_runtime};
        sum_next   = sum_wide[RT_W] ? '1 : sum_wide[RT_W-1:0];
        limit_next = LIMIT_W'({1'b0, cur_level} + (LEVEL_W + 1)'(1)) * LIMIT_W'(base_quantum);
        elapsed    = now_time - last_reset;
        due_next   = elapsed >= TIME_W'(reset_period);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sum_reg   <= sum_next;
            limit_reg <= limit_next;
            level_reg <= cur_level;
            due_reg   <= due_next;
        end
    end

    assign demote      = (level_reg < LAST_LEVEL) && (LIMIT_W'(sum_reg) >= limit_reg);
    assign res.demote  = demote;
    assign res.level   = demote ? level_reg + LEVEL_W'(1) : level_reg;
    assign res.runtime = demote ? '0 : sum_reg;
    assign res.due     = due_reg;

endmodule

FILE: dv/mlfq_process_table_test.sv
`timescale 1ns / 1ps

module mlfq_process_table_test;
    import mlfq_pkg::*;

    localparam int CYCLE_LIMIT = 500000;

    class sched_table_tracker;
        bit        used [NUM_SLOTS_DEF];
        bit [15:0] owner [NUM_SLOTS_DEF];
        bit [2:0]  level [NUM_SLOTS_DEF];
        bit [31:0] spent [NUM_SLOTS_DEF];
        bit [15:0] next_pid;
        bit [63:0] last_flush;
        bit [31:0] quantum;
        bit [31:0] period;
        bit [15:0] shell;
        rsp_t      replies_due[$];
        int        errors;

        function new();
            foreach (used[i])
            begin
                used[i] = 1'b0;
                owner[i] = '0;
                level[i] = '0;
                spent[i] = '0;
            end
            next_pid = '0;
            last_flush = '0;
            quantum = BASE_QUANTUM_RST;
            period = RESET_PERIOD_RST;
            shell = SHELL_PID_RST;
            errors = 0;
        endfunction

        function int slot_of(bit [15:0] p);
            for (int i = 0; i < NUM_SLOTS_DEF; i++)
            begin
                if (used[i] && owner[i] == p)
                    return i;
            end
            return -1;
        endfunction

        function bit [2:0] level_of(bit [15:0] p);
            int s;
            s = slot_of(p);
            return (s < 0) ? 3'd0 : level[s];
        endfunction

        function bit pick_live(output bit [15:0] p);
            int cand[$];
            p = '0;
            foreach (used[i])
            begin
                if (used[i])
                    cand.push_back(i);
            end
            if (cand.size() == 0)
                return 1'b0;
            p = owner[cand[$urandom_range(0, cand.size() - 1)]];
            return 1'b1;
        endfunction

        function int outstanding();
            return replies_due.size();
        endfunction

        function void set_register(cfg_reg_t idx, bit [31:0] v);
            case (idx)
                CFG_BASE_QUANTUM: quantum = v;
                CFG_RESET_PERIOD: period = v;
                CFG_SHELL_PID:    shell = v[15:0];
                default: ;
            endcase
        endfunction

        function void note_request(req_t r);
            rsp_t      e;
            int        s;
            int        k;
            bit        found;
            bit [63:0] sum;
            bit [63:0] lim;
            e = '0;
            e.pid_out = r.pid;
            case (r.req_type)
                REQ_ALLOC:
                begin
                    s = -1;
                    for (int i = 0; i < NUM_SLOTS_DEF; i++)
                    begin
                        if (!used[i] && s < 0)
                            s = i;
                    end
                    if (s < 0)
                    begin
                        e.status = STAT_FULL;
                        e.pid_out = '0;
                    end
                    else
                    begin
                        next_pid++;
                        used[s] = 1'b1;
                        owner[s] = next_pid;
                        level[s] = '0;
                        spent[s] = '0;
                        e.pid_out = next_pid;
                    end
                end
                REQ_CHARGE:
                begin
                    s = slot_of(r.pid);
                    if (s < 0)
                        e.status = STAT_NOT_FOUND;
                    else
                    begin
                        sum = {32'b0, spent[s]} + {32'b0, r.runtime};
                        if (sum > 64'hFFFF_FFFF)
                            sum = 64'hFFFF_FFFF;
                        spent[s] = sum[31:0];
                        lim = ({61'b0, level[s]} + 64'd1) * {32'b0, quantum};
                        if (level[s] < NUM_LEVELS_DEF - 1 && sum >= lim)
                        begin
                            level[s]++;
                            spent[s] = '0;
                            e.demoted = 1'b1;
                        end
                    end
                    if (r.tty_pending)
                    begin
                        k = slot_of(shell);
                        if (k >= 0)
                        begin
                            level[k] = '0;
                            spent[k] = '0;
                        end
                    end
                    if (r.now_time - last_flush >= {32'b0, period})
                    begin
                        foreach (used[i])
                        begin
                            if (used[i])
                            begin
                                level[i] = '0;
                                spent[i] = '0;
                            end
                        end
                        last_flush = r.now_time;
                        e.global_reset = 1'b1;
                    end
                    if (s >= 0)
                        e.level_out = level[s];
                end
                REQ_FREE:
                begin
                    found = 1'b0;
                    foreach (used[i])
                    begin
                        if (used[i] && owner[i] == r.pid)
                        begin
                            used[i] = 1'b0;
                            found = 1'b1;
                        end
                    end
                    if (!found)
                        e.status = STAT_NOT_FOUND;
                end
                default: ;
            endcase
            replies_due.push_back(e);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            end
        endfunction

        function void check_response(rsp_t got);
            rsp_t want;
            if (replies_due.size() == 0)
            begin
                errors++;
                $display("%0t: response with no request outstanding, expected none, got %h",
                         $time, got);
                return;
            end
            want = replies_due.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("pid_out", want.pid_out, got.pid_out);
            compare_field("level_out", want.level_out, got.level_out);
            compare_field("demoted", want.demoted, got.demoted);
            compare_field("global_reset", want.global_reset, got.global_reset);
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 req_valid;
    logic                 req_stall;
    req_t                 req;
    logic                 rsp_valid;
    logic                 rsp_stall;
    rsp_t                 rsp;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    int unsigned          cycle_count = 0;
    int                   stall_pct = 0;
    int                   gap_pct = 0;
    bit [63:0]            wall_us = '0;
    sched_table_tracker   board;

    mlfq_process_table uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            board.check_response(rsp);
    end

    initial
    begin : rsp_backpressure
        int burst;
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct)
            begin
                burst = $urandom_range(1, 6);
                rsp_stall <= 1'b1;
                repeat (burst) @(negedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    function automatic bit [31:0] fit32(bit [63:0] v);
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic req_t request_of(req_kind_t kind, bit [15:0] p, bit [31:0] rt,
                                        bit [63:0] now, bit tty);
        req_t r;
        r.req_type = kind;
        r.pid = p;
        r.runtime = rt;
        r.now_time = now;
        r.tty_pending = tty;
        return r;
    endfunction

    // Mostly charges against live pids, with runtimes spread around the demotion limit.
    function automatic req_t compose_request();
        req_t      r;
        bit [15:0] p;
        bit [2:0]  lv;
        bit [63:0] lim;
        bit [63:0] span;
        bit        live;
        int        pick;
        r.pid = 16'($urandom);
        r.runtime = $urandom;
        r.now_time = {$urandom, $urandom};
        r.tty_pending = ($urandom_range(0, 4) == 0);
        live = board.pick_live(p);
        pick = $urandom_range(0, 99);
        if (pick < 18)
            r.req_type = REQ_ALLOC;
        else if (pick < 32)
        begin
            r.req_type = REQ_FREE;
            if (live && $urandom_range(0, 4) != 0)
                r.pid = p;
        end
        else if (pick < 35)
            r.req_type = REQ_NOP;
        else
        begin
            r.req_type = REQ_CHARGE;
            if (live && $urandom_range(0, 7) != 0)
                r.pid = p;
            lv = board.level_of(r.pid);
            lim = ({61'b0, lv} + 64'd1) * {32'b0, board.quantum};
            span = lim / 64'd2 + 64'd1;
            case ($urandom_range(0, 9))
                0: r.runtime = '0;
                1: r.runtime = '1;
                2, 3: r.runtime = $urandom;
                4, 5: r.runtime = fit32(lim + 64'($urandom_range(0, 4)) - 64'd2);
                default: r.runtime = fit32({$urandom, $urandom} % span);
            endcase
            case ($urandom_range(0, 19))
                0: wall_us = {$urandom, $urandom};
                1, 2: wall_us += {32'b0, board.period} + 64'($urandom_range(0, 100));
                default: wall_us += {32'b0, $urandom} % ({32'b0, board.period} / 64'd16 + 64'd1);
            endcase
            r.now_time = wall_us;
        end
        return r;
    endfunction

    task automatic feed(input req_t r);
        if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        req <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall !== 1'b0)
            @(posedge clk);
        board.note_request(r);
        @(negedge clk);
    endtask

    task automatic drain_replies();
        req_valid <= 1'b0;
        do
            @(negedge clk);
        while (board.outstanding() != 0);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input bit [31:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        board.set_register(idx, val);
        @(negedge clk);
    endtask

    task automatic program_regs(input bit [31:0] bq, input bit [31:0] rp, input bit [15:0] sp);
        write_reg(CFG_BASE_QUANTUM, bq);
        write_reg(CFG_RESET_PERIOD, rp);
        write_reg(CFG_SHELL_PID, {16'b0, sp});
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input bit [31:0] bq, input bit [31:0] rp, input bit [15:0] sp,
                             input bit shell_live, input int count, input int stall,
                             input int gap);
        bit [15:0] p;
        drain_replies();
        repeat (25) @(negedge clk);
        if (shell_live && board.pick_live(p))
            sp = p;
        program_regs(bq, rp, sp);
        stall_pct = stall;
        gap_pct = gap;
        repeat (count)
        begin
            if ($urandom_range(0, 199) == 0)
                drain_replies();
            feed(compose_request());
        end
    endtask

    initial
    begin : stimulus
        board = new();
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        stall_pct = 20;
        gap_pct = 20;

        feed(request_of(REQ_NOP, 16'hFFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1));
        feed(request_of(REQ_CHARGE, 16'h0000, 32'd0, 64'd0, 1'b0));
        feed(request_of(REQ_FREE, 16'hFFFF, 32'd0, 64'd0, 1'b0));
        for (int i = 0; i < NUM_SLOTS_DEF; i++)
            feed(request_of(REQ_ALLOC, (i % 2) ? 16'hFFFF : 16'h0000, 32'd0, 64'd0, 1'b0));
        feed(request_of(REQ_ALLOC, 16'h0000, 32'd0, 64'd0, 1'b0));
        // Demotion at the limit, then a charge of the largest runtime, then the shell boost.
        feed(request_of(REQ_CHARGE, 16'd1, 32'd100000, 64'd1000, 1'b0));
        feed(request_of(REQ_CHARGE, 16'd1, 32'hFFFF_FFFF, 64'd2000, 1'b0));
        feed(request_of(REQ_CHARGE, 16'd2, 32'd99999, 64'd3000, 1'b1));
        // Demotion followed by the periodic reset, then a clock that has gone backwards.
        feed(request_of(REQ_CHARGE, 16'd3, 32'd100000, 64'd10000000, 1'b0));
        feed(request_of(REQ_CHARGE, 16'h8000, 32'd7, 64'd5, 1'b0));
        feed(request_of(REQ_FREE, 16'd16, 32'd0, 64'd0, 1'b0));
        feed(request_of(REQ_ALLOC, 16'd0, 32'd0, 64'd0, 1'b0));
        feed(request_of(REQ_FREE, 16'd5, 32'd0, 64'd0, 1'b0));
        feed(request_of(REQ_FREE, 16'd5, 32'd0, 64'd0, 1'b0));
        wall_us = 64'd10;

        run_phase(32'd1000, 32'd50000, 16'd0, 1'b1, 230, 25, 25);
        run_phase(32'd0, 32'd0, 16'h0000, 1'b0, 80, 10, 40);
        run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 200, 40, 10);
        run_phase(32'd1, 32'd1, 16'd0, 1'b1, 150, 0, 0);
        run_phase(32'd20000, 32'd3000000, 16'd0, 1'b1, 330, 30, 30);
        run_phase($urandom, $urandom, 16'($urandom), 1'b0, 330, 15, 15);
        run_phase(32'd100000, 32'd10000000, 16'd0, 1'b1, 300, 0, 0);

        drain_replies();
        repeat (30) @(negedge clk);
        if (board.errors == 0 && board.outstanding() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
